// File: hdl/pcxrle_pkg.sv
// shared types and constants of the pcx run-length line encoder
package pcxrle_pkg;

    localparam int RUN_W = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic [7:0] COUNT_MARK = 8'hC0;
    localparam logic [7:0] LITERAL_LIMIT = 8'hC0;

    // one run to be written out: value and length
    typedef struct packed {
        logic             valid;
        logic [7:0]       value;
        logic [RUN_W-1:0] length;
    } run_t;

    // work handed from front to back: the run closed by a break, the run flushed at
    // end of line, and the line flag
    typedef struct packed {
        run_t closed;
        run_t flushed;
        logic eol;
    } cmd_t;

    // queue handshake between front and back
    typedef struct packed {
        logic push;
        cmd_t data;
    } q_wr_t;

    typedef struct packed {
        logic full;
    } q_wr_stat_t;

    typedef struct packed {
        logic empty;
        cmd_t head;
    } q_rd_stat_t;

endpackage

// File: hdl/pcxrle_if.sv
// valid/ready channel interfaces for pixel items and code items
interface pcxrle_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       end_of_line;

    modport source (output valid, output pixel_byte, output end_of_line, input ready);
    modport sink (input valid, input pixel_byte, input end_of_line, output ready);
endinterface

interface pcxrle_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_of_item;
    logic       line_done;

    modport source (output valid, output code_byte, output last_of_item, output line_done,
                    input ready);
    modport sink (input valid, input code_byte, input last_of_item, input line_done,
                  output ready);
endinterface

// File: hdl/pcxrle_front.sv
// front end: tracks the open run and classifies each pixel item into emit work
module pcxrle_front
    import pcxrle_pkg::*;
#(
    parameter int MAX_RUN = 63
)
(
    input  logic       clk,
    input  logic       rst_n,
    pcxrle_in_if.sink  pixel_in,
    output q_wr_t      q_wr,
    input  q_wr_stat_t q_stat
);

    localparam logic [RUN_W-1:0] MaxRunC = RUN_W'(MAX_RUN);

    logic [7:0]       run_value_reg, run_value_next;
    logic [RUN_W-1:0] run_length_reg, run_length_next;
    logic             fire;
    logic             starting;
    logic             extend;
    logic             brk;
    logic [RUN_W-1:0] new_length;

    assign pixel_in.ready = !q_stat.full;
    assign fire = pixel_in.valid && pixel_in.ready;

    assign starting = (run_length_reg == '0);
    assign extend = !starting && (pixel_in.pixel_byte == run_value_reg)
                    && (run_length_reg < MaxRunC);
    assign brk = !starting && !extend;
    assign new_length = extend ? run_length_reg + RUN_W'(1) : RUN_W'(1);

    always_comb
    begin
        q_wr.push = fire && (brk || pixel_in.end_of_line);
        q_wr.data.closed.valid = brk;
        q_wr.data.closed.value = run_value_reg;
        q_wr.data.closed.length = run_length_reg;
        // the run that holds the current byte, flushed at end of line
        q_wr.data.flushed.valid = pixel_in.end_of_line;
        q_wr.data.flushed.value = pixel_in.pixel_byte;
        q_wr.data.flushed.length = new_length;
        q_wr.data.eol = pixel_in.end_of_line;

        run_value_next = run_value_reg;
        run_length_next = run_length_reg;
        if (fire)
        begin
            if (pixel_in.end_of_line)
            begin
                run_value_next = '0;
                run_length_next = '0;
            end
            else
            begin
                run_value_next = pixel_in.pixel_byte;
                run_length_next = new_length;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_value_reg <= '0;
            run_length_reg <= '0;
        end
        else
        begin
            run_value_reg <= run_value_next;
            run_length_reg <= run_length_next;
        end
    end

    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        run_length_reg <= MaxRunC)
        else $error("open run longer than the maximum");

    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && pixel_in.end_of_line |=> run_length_reg == '0)
        else $error("run not cleared after end of line");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_wr.push |-> !q_stat.full)
        else $error("push into a full queue");

endmodule

// File: hdl/pcxrle_queue.sv
// short command queue between the front and back ends
module pcxrle_queue
    import pcxrle_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  q_wr_t      q_wr,
    output q_wr_stat_t q_stat,
    input  logic       pop,
    output q_rd_stat_t rd_stat
);

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign q_stat.full = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_stat.empty = (count_reg == '0);
    assign rd_stat.head = mem_reg[rd_ptr_reg];
    assign do_pop = pop && !rd_stat.empty;

    always_comb
    begin
        wr_ptr_next = q_wr.push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next = count_reg;
        if (q_wr.push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (do_pop && !q_wr.push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            mem_reg[wr_ptr_reg] <= q_wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with count");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !rd_stat.empty)
        else $error("pop from an empty queue");

endmodule

// File: hdl/pcxrle_back.sv
// back end: expands queued runs into literal, count and value bytes
module pcxrle_back
    import pcxrle_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  q_rd_stat_t  rd_stat,
    output logic        pop,
    pcxrle_out_if.source code_out
);

    logic [7:0] list [4];
    logic [1:0] a_n;
    logic [2:0] total;
    logic       a_lit;
    logic       b_lit;

    logic [7:0] bytes_reg [4];
    logic [1:0] idx_reg, idx_next;
    logic [1:0] last_idx_reg;
    logic       eol_reg;
    logic       busy_reg, busy_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] code_reg;
    logic       last_reg;
    logic       done_reg;

    logic       can_load;
    logic       emit;
    logic       finishing;

    // byte list of the command at the head of the queue
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            list[i] = '0;
        end
        a_lit = (rd_stat.head.closed.length == RUN_W'(1))
                && (rd_stat.head.closed.value < LITERAL_LIMIT);
        b_lit = (rd_stat.head.flushed.length == RUN_W'(1))
                && (rd_stat.head.flushed.value < LITERAL_LIMIT);
        a_n = 2'd0;
        if (rd_stat.head.closed.valid)
        begin
            if (a_lit)
            begin
                list[0] = rd_stat.head.closed.value;
                a_n = 2'd1;
            end
            else
            begin
                list[0] = COUNT_MARK | {2'b00, rd_stat.head.closed.length};
                list[1] = rd_stat.head.closed.value;
                a_n = 2'd2;
            end
        end
        total = {1'b0, a_n};
        if (rd_stat.head.flushed.valid)
        begin
            if (b_lit)
            begin
                list[a_n] = rd_stat.head.flushed.value;
                total = {1'b0, a_n} + 3'd1;
            end
            else
            begin
                list[a_n] = COUNT_MARK | {2'b00, rd_stat.head.flushed.length};
                list[a_n + 2'd1] = rd_stat.head.flushed.value;
                total = {1'b0, a_n} + 3'd2;
            end
        end
    end

    assign can_load = !out_valid_reg || code_out.ready;
    assign emit = busy_reg && can_load;
    assign finishing = emit && (idx_reg == last_idx_reg);
    // next command is taken as the current one sends its last byte
    assign pop = (!busy_reg || finishing) && !rd_stat.empty;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next = '0;
        end
        else if (finishing)
        begin
            busy_next = 1'b0;
        end
        else if (emit)
        begin
            idx_next = idx_reg + 2'd1;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (code_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < 4; i++)
            begin
                bytes_reg[i] <= list[i];
            end
            last_idx_reg <= 2'(total - 3'd1);
            eol_reg <= rd_stat.head.eol;
        end
        if (emit)
        begin
            code_reg <= bytes_reg[idx_reg];
            last_reg <= (idx_reg == last_idx_reg);
            done_reg <= (idx_reg == last_idx_reg) && eol_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign code_out.valid = out_valid_reg;
    assign code_out.code_byte = code_reg;
    assign code_out.last_of_item = last_reg;
    assign code_out.line_done = done_reg;

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> last_reg)
        else $error("line done on a byte that is not the last of its item");

    a_idx_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> idx_reg <= last_idx_reg)
        else $error("byte index past the end of the list");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !code_out.ready |=> out_valid_reg && $stable(code_reg))
        else $error("stalled output byte changed");

endmodule

// File: hdl/pcx_rle_line_encoder.sv
// PCX run-length encoder for one plane of a scan line: top level
// The block takes one pixel item per cycle as long as its four-entry command queue has
// room. Bytes that extend the open run produce nothing; a run break produces one or two
// code bytes, and an end-of-line item up to four. The back end sends one code byte per
// cycle while the output is ready, so sustained throughput is set by the single-byte
// output port: an item costs its input transfer, or the output of the code bytes it
// causes when they are more (up to four), and the queue absorbs bursts.
// An accepted item passes through the queue, the byte list and the output code register.
module pcx_rle_line_encoder
    import pcxrle_pkg::*;
#(
    parameter int MAX_RUN = 63
)
(
    input  logic         clk,
    input  logic         rst_n,
    pcxrle_in_if.sink    pixel_in,
    pcxrle_out_if.source code_out
);

    q_wr_t      q_wr;
    q_wr_stat_t q_stat;
    q_rd_stat_t rd_stat;
    logic       pop;

    pcxrle_front #(
        .MAX_RUN (MAX_RUN)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .pixel_in (pixel_in),
        .q_wr     (q_wr),
        .q_stat   (q_stat)
    );

    pcxrle_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_wr    (q_wr),
        .q_stat  (q_stat),
        .pop     (pop),
        .rd_stat (rd_stat)
    );

    pcxrle_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_stat  (rd_stat),
        .pop      (pop),
        .code_out (code_out)
    );

endmodule
